// ----- hw/rtl/tgs_pkg.sv -----
// Shared constants, types and state encodings of the topic Gibbs token sampler.
package tgs_pkg;

    localparam int NUM_TOPICS_DEF  = 64;
    localparam int VOCAB_SIZE_DEF  = 4096;
    localparam int NUM_AUTHORS_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 20;

    localparam int TOTAL_WIDTH  = 24;
    localparam int WEIGHT_WIDTH = 48;
    localparam int FRAC_BITS    = 16;
    localparam int PRIOR_WIDTH  = 32;
    localparam int DEN_WIDTH    = TOTAL_WIDTH + FRAC_BITS + 1;

    localparam int WORD_ID_WIDTH   = 12;
    localparam int AUTHOR_ID_WIDTH = 10;
    localparam int CITED_ID_WIDTH  = 11;
    localparam int TOPIC_WIDTH     = 6;
    localparam int UNIFORM_WIDTH   = 16;
    localparam int PAIR_WIDTH      = 11;

    localparam int RED_BITS  = 12;
    localparam int RCP_SHIFT = 24;

    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ALPHA      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BETA       = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_VOCAB_BETA = 2'd2;

    localparam logic [PRIOR_WIDTH-1:0] ALPHA_RESET      = 32'd51200;
    localparam logic [PRIOR_WIDTH-1:0] BETA_RESET       = 32'd655;
    localparam logic [PRIOR_WIDTH-1:0] VOCAB_BETA_RESET = 32'd2684355;
    localparam logic [PAIR_WIDTH-1:0]  PAIR_NONE        = 11'h7FF;

    localparam logic ACT_RESAMPLE = 1'b0;
    localparam logic ACT_INIT     = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_REM,
        S_BASE,
        S_RD_OLD,
        S_UPD_OLD,
        S_RD_T,
        S_WT_START,
        S_WT_WAIT,
        S_SCALE,
        S_DRAW_RD,
        S_DRAW,
        S_RD_NEW,
        S_UPD_NEW,
        S_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        WU_IDLE,
        WU_MUL,
        WU_CHK,
        WU_DIV
    } wu_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wu_stat_t;

endpackage

// ----- hw/rtl/topic_gibbs_token_sampler.sv -----
// Top level of the topic Gibbs token sampler: sequencer, count memories and draw.
//
// Channels: the input beat (in_valid/in_ready) carries one token; the output
// beat (out_valid/out_ready) returns its topic and a count error flag, one
// result per token, in order. The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) sets alpha, beta and vocabulary times beta; it is always
// ready. The user must write it only while the block is idle; it is not enforced.
// Timing: a resample computes a weight for each topic in turn, then walks the
// topics in order up to the drawn one. Most of the work is in the weight unit:
// a multiply in 16-bit chunks, then, unless the divisor is zero or the quotient
// saturates, one quotient bit per cycle for 48 bits, per topic. An init beat
// or a count error skips the weights and the draw. One token is in work at a
// time.
// Reset: counts are zeroed by a clearing pass over every address of the count
// memories, during which in_ready stays low.
// Stall: a finished result waits in the output register; the next token is
// accepted meanwhile, and its result is held until the previous beat leaves.
module topic_gibbs_token_sampler
    import tgs_pkg::*;
#(
    parameter int NUM_TOPICS  = NUM_TOPICS_DEF,
    parameter int VOCAB_SIZE  = VOCAB_SIZE_DEF,
    parameter int NUM_AUTHORS = NUM_AUTHORS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [WORD_ID_WIDTH-1:0]     word_id,
    input  logic [AUTHOR_ID_WIDTH-1:0]   author_id,
    input  logic signed [CITED_ID_WIDTH-1:0] cited_id,
    input  logic [TOPIC_WIDTH-1:0]       old_topic,
    input  logic [UNIFORM_WIDTH-1:0]     uniform,
    input  logic                         held_out,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [TOPIC_WIDTH-1:0]       new_topic,
    output logic                         count_error,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [PRIOR_WIDTH-1:0]       cfg_data
);

    localparam int TW        = $clog2(NUM_TOPICS);
    localparam int WIW       = $clog2(VOCAB_SIZE);
    localparam int AIW       = $clog2(NUM_AUTHORS);
    localparam int WT_DEPTH  = VOCAB_SIZE * NUM_TOPICS;
    localparam int AT_DEPTH  = NUM_AUTHORS * NUM_TOPICS;
    localparam int WAW       = $clog2(WT_DEPTH);
    localparam int AAW       = $clog2(AT_DEPTH);
    localparam int CLR_DEPTH = (WT_DEPTH > AT_DEPTH) ? WT_DEPTH : AT_DEPTH;
    localparam int CLW       = $clog2(CLR_DEPTH) + 1;
    localparam int ZW        = WEIGHT_WIDTH + TW;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PRW       = RED_BITS + RCP_W;

    localparam logic [RCP_W-1:0] W_RCP = RCP_W'((2**RCP_SHIFT + VOCAB_SIZE - 1) / VOCAB_SIZE);
    localparam logic [RCP_W-1:0] A_RCP = RCP_W'((2**RCP_SHIFT + NUM_AUTHORS - 1) / NUM_AUTHORS);
    localparam logic [RCP_W-1:0] T_RCP = RCP_W'((2**RCP_SHIFT + NUM_TOPICS - 1) / NUM_TOPICS);

    seq_state_t state_reg, state_next;

    logic [PRIOR_WIDTH-1:0]     alpha_reg, beta_reg, vbeta_reg;
    logic [PAIR_WIDTH-1:0]      prev_author_reg, prev_cited_reg;
    logic [CLW-1:0]             clr_reg;

    logic                       action_reg, held_reg;
    logic [AUTHOR_ID_WIDTH-1:0] author_raw_reg;
    logic [CITED_ID_WIDTH-1:0]  cited_raw_reg;
    logic [UNIFORM_WIDTH-1:0]   uniform_reg;
    logic [RED_BITS-1:0]        w_in_reg, a_in_reg, c_in_reg, t_in_reg;
    logic [RED_BITS-1:0]        w_q_reg, a_q_reg, c_q_reg, t_q_reg;
    logic [WIW-1:0]             w_rem_reg;
    logic [AIW-1:0]             a_rem_reg, c_rem_reg;
    logic [TW-1:0]              t_rem_reg;
    logic [WAW-1:0]             wbase_reg;
    logic [AAW-1:0]             abase_reg, cbase_reg;

    logic                       use_cite_reg, err_reg;
    logic [TW-1:0]              t_reg, pick_reg;
    logic [ZW-1:0]              z_reg, u_reg, run_reg;

    logic                       out_valid_reg, count_error_reg;
    logic [TOPIC_WIDTH-1:0]     new_topic_reg;

    logic [PRW-1:0]             w_prod, a_prod, c_prod, t_prod;

    logic [TW-1:0]              sel_t;
    logic [WAW-1:0]             wt_addr;
    logic [AAW-1:0]             at_addr, ct_addr;
    logic                       clearing;
    logic [COUNT_WIDTH-1:0]     wt_rd, at_rd, ct_rd;
    logic [TOTAL_WIDTH-1:0]     tot_rd, ctot_rd;
    logic [WEIGHT_WIDTH-1:0]    wg_rd;
    logic [COUNT_WIDTH-1:0]     wt_wd, at_wd, ct_wd;
    logic [TOTAL_WIDTH-1:0]     tot_wd, ctot_wd;
    logic                       base_we, cite_we;
    logic                       wt_we, at_we, ct_we, tot_we, ctot_we;
    logic                       op_inc, has_cite, pair_new, use_cite_now, is_err;
    logic                       out_load, t_last, advance;
    logic [ZW-1:0]              run_n;
    logic [ZW+UNIFORM_WIDTH-1:0] scale_prod;

    logic [WEIGHT_WIDTH-1:0]    wu_weight;
    wu_stat_t                   wu_stat;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
            vbeta_reg <= VOCAB_BETA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA:      alpha_reg <= cfg_data;
                CFG_BETA:       beta_reg  <= cfg_data;
                CFG_VOCAB_BETA: vbeta_reg <= cfg_data;
                default:        alpha_reg <= alpha_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // index reduction by reciprocal multiply
    assign w_prod = PRW'(w_in_reg) * PRW'(W_RCP);
    assign a_prod = PRW'(a_in_reg) * PRW'(A_RCP);
    assign c_prod = PRW'(c_in_reg) * PRW'(A_RCP);
    assign t_prod = PRW'(t_in_reg) * PRW'(T_RCP);

    assign has_cite     = !cited_raw_reg[CITED_ID_WIDTH-1];
    assign pair_new     = ({1'b0, author_raw_reg} != prev_author_reg) ||
                          (cited_raw_reg != prev_cited_reg);
    assign use_cite_now = !held_reg && has_cite && pair_new;
    assign is_err       = (action_reg == ACT_RESAMPLE) && !held_reg && (at_rd == '0);

    always_comb
    begin
        case (state_reg)
            S_RD_OLD, S_UPD_OLD: sel_t = t_rem_reg;
            S_RD_NEW, S_UPD_NEW: sel_t = pick_reg;
            default:             sel_t = t_reg;
        endcase
    end

    assign wt_addr  = wbase_reg + WAW'(sel_t);
    assign at_addr  = abase_reg + AAW'(sel_t);
    assign ct_addr  = cbase_reg + AAW'(sel_t);
    assign clearing = state_reg == S_CLEAR;

    assign op_inc  = (state_reg == S_UPD_NEW) || (action_reg == ACT_INIT);
    assign base_we = ((state_reg == S_UPD_OLD) && !is_err) || (state_reg == S_UPD_NEW);
    assign cite_we = ((state_reg == S_UPD_OLD) &&
                      ((action_reg == ACT_INIT) ? (has_cite && !held_reg) :
                                                  (!is_err && use_cite_now))) ||
                     ((state_reg == S_UPD_NEW) && use_cite_reg);

    assign wt_we   = base_we || (clearing && (clr_reg < CLW'(WT_DEPTH)));
    assign at_we   = base_we || (clearing && (clr_reg < CLW'(AT_DEPTH)));
    assign tot_we  = base_we || (clearing && (clr_reg < CLW'(NUM_TOPICS)));
    assign ct_we   = cite_we || (clearing && (clr_reg < CLW'(AT_DEPTH)));
    assign ctot_we = cite_we || (clearing && (clr_reg < CLW'(NUM_TOPICS)));

    assign wt_wd   = clearing ? '0 :
                     op_inc ? ((wt_rd == '1) ? wt_rd : wt_rd + COUNT_WIDTH'(1)) :
                              ((wt_rd == '0) ? wt_rd : wt_rd - COUNT_WIDTH'(1));
    assign at_wd   = clearing ? '0 :
                     op_inc ? ((at_rd == '1) ? at_rd : at_rd + COUNT_WIDTH'(1)) :
                              ((at_rd == '0) ? at_rd : at_rd - COUNT_WIDTH'(1));
    assign ct_wd   = clearing ? '0 :
                     op_inc ? ((ct_rd == '1) ? ct_rd : ct_rd + COUNT_WIDTH'(1)) :
                              ((ct_rd == '0) ? ct_rd : ct_rd - COUNT_WIDTH'(1));
    assign tot_wd  = clearing ? '0 :
                     op_inc ? ((tot_rd == '1) ? tot_rd : tot_rd + TOTAL_WIDTH'(1)) :
                              ((tot_rd == '0) ? tot_rd : tot_rd - TOTAL_WIDTH'(1));
    assign ctot_wd = clearing ? '0 :
                     op_inc ? ((ctot_rd == '1) ? ctot_rd : ctot_rd + TOTAL_WIDTH'(1)) :
                              ((ctot_rd == '0) ? ctot_rd : ctot_rd - TOTAL_WIDTH'(1));

    tgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(WT_DEPTH)) u_word_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (clearing ? clr_reg[WAW-1:0] : wt_addr),
        .wdata (wt_wd),
        .raddr (wt_addr),
        .rdata (wt_rd)
    );

    tgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(AT_DEPTH)) u_author_ram (
        .clk   (clk),
        .we    (at_we),
        .waddr (clearing ? clr_reg[AAW-1:0] : at_addr),
        .wdata (at_wd),
        .raddr (at_addr),
        .rdata (at_rd)
    );

    tgs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(AT_DEPTH)) u_cited_ram (
        .clk   (clk),
        .we    (ct_we),
        .waddr (clearing ? clr_reg[AAW-1:0] : ct_addr),
        .wdata (ct_wd),
        .raddr (ct_addr),
        .rdata (ct_rd)
    );

    tgs_ram #(.WIDTH(TOTAL_WIDTH), .DEPTH(NUM_TOPICS)) u_total_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (clearing ? clr_reg[TW-1:0] : sel_t),
        .wdata (tot_wd),
        .raddr (sel_t),
        .rdata (tot_rd)
    );

    tgs_ram #(.WIDTH(TOTAL_WIDTH), .DEPTH(NUM_TOPICS)) u_cited_total_ram (
        .clk   (clk),
        .we    (ctot_we),
        .waddr (clearing ? clr_reg[TW-1:0] : sel_t),
        .wdata (ctot_wd),
        .raddr (sel_t),
        .rdata (ctot_rd)
    );

    tgs_ram #(.WIDTH(WEIGHT_WIDTH), .DEPTH(NUM_TOPICS)) u_weight_ram (
        .clk   (clk),
        .we    ((state_reg == S_WT_WAIT) && wu_stat.done),
        .waddr (t_reg),
        .wdata (wu_weight),
        .raddr (t_reg),
        .rdata (wg_rd)
    );

    tgs_weight_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_weight (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        ((state_reg == S_WT_START) && !wu_stat.busy),
        .acnt         (at_rd),
        .wcnt         (wt_rd),
        .tot          (tot_rd),
        .alpha_q      (alpha_reg),
        .beta_q       (beta_reg),
        .vocab_beta_q (vbeta_reg),
        .weight       (wu_weight),
        .stat         (wu_stat)
    );

    assign t_last     = t_reg == TW'(NUM_TOPICS - 1);
    assign run_n      = run_reg + ZW'(wg_rd);
    assign advance    = (u_reg > run_n) && !t_last;
    assign scale_prod = z_reg * uniform_reg;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLW'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:   state_next = S_REM;
            S_REM:      state_next = S_BASE;
            S_BASE:     state_next = S_RD_OLD;
            S_RD_OLD:   state_next = S_UPD_OLD;
            S_UPD_OLD:
            begin
                if ((action_reg == ACT_INIT) || is_err)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD_T;
                end
            end
            S_RD_T:     state_next = S_WT_START;
            S_WT_START: state_next = S_WT_WAIT;
            S_WT_WAIT:
            begin
                if (wu_stat.done)
                begin
                    state_next = t_last ? S_SCALE : S_RD_T;
                end
            end
            S_SCALE:    state_next = S_DRAW_RD;
            S_DRAW_RD:  state_next = S_DRAW;
            S_DRAW:     state_next = advance ? S_DRAW_RD : S_RD_NEW;
            S_RD_NEW:   state_next = S_UPD_NEW;
            S_UPD_NEW:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= '0;
            prev_author_reg <= PAIR_NONE;
            prev_cited_reg  <= PAIR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + CLW'(1);
            end
            if ((state_reg == S_UPD_NEW) && !held_reg)
            begin
                prev_author_reg <= {1'b0, author_raw_reg};
                prev_cited_reg  <= cited_raw_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // token datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                action_reg     <= action;
                held_reg       <= held_out;
                author_raw_reg <= author_id;
                cited_raw_reg  <= cited_id;
                uniform_reg    <= uniform;
                w_in_reg       <= RED_BITS'(word_id);
                a_in_reg       <= RED_BITS'(author_id);
                c_in_reg       <= RED_BITS'(cited_id[CITED_ID_WIDTH-2:0]);
                t_in_reg       <= RED_BITS'(old_topic);
            end
            S_REDUCE:
            begin
                w_q_reg <= w_prod[RCP_SHIFT +: RED_BITS];
                a_q_reg <= a_prod[RCP_SHIFT +: RED_BITS];
                c_q_reg <= c_prod[RCP_SHIFT +: RED_BITS];
                t_q_reg <= t_prod[RCP_SHIFT +: RED_BITS];
            end
            S_REM:
            begin
                w_rem_reg <= WIW'(w_in_reg - w_q_reg * RED_BITS'(VOCAB_SIZE));
                a_rem_reg <= AIW'(a_in_reg - a_q_reg * RED_BITS'(NUM_AUTHORS));
                c_rem_reg <= AIW'(c_in_reg - c_q_reg * RED_BITS'(NUM_AUTHORS));
                t_rem_reg <= TW'(t_in_reg - t_q_reg * RED_BITS'(NUM_TOPICS));
            end
            S_BASE:
            begin
                wbase_reg <= WAW'(w_rem_reg) * WAW'(NUM_TOPICS);
                abase_reg <= AAW'(a_rem_reg) * AAW'(NUM_TOPICS);
                cbase_reg <= AAW'(c_rem_reg) * AAW'(NUM_TOPICS);
            end
            S_UPD_OLD:
            begin
                err_reg      <= is_err;
                pick_reg     <= t_rem_reg;
                use_cite_reg <= use_cite_now;
                t_reg        <= '0;
                z_reg        <= '0;
            end
            S_WT_WAIT:
            begin
                if (wu_stat.done)
                begin
                    z_reg <= z_reg + ZW'(wu_weight);
                    if (!t_last)
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end
            end
            S_SCALE:
            begin
                u_reg   <= scale_prod[ZW+UNIFORM_WIDTH-1:UNIFORM_WIDTH];
                t_reg   <= '0;
                run_reg <= '0;
            end
            S_DRAW:
            begin
                if (advance)
                begin
                    run_reg <= run_n;
                    t_reg   <= t_reg + TW'(1);
                end
                else
                begin
                    pick_reg <= t_reg;
                end
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
        if (out_load)
        begin
            new_topic_reg   <= TOPIC_WIDTH'(pick_reg);
            count_error_reg <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_topic   = new_topic_reg;
    assign count_error = count_error_reg;

endmodule

// ----- hw/rtl/tgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tgs_weight_unit.sv -----
// Topic weight unit: (a*b)/d as a Q32.16 weight by chunked multiply and bit-serial divide.
module tgs_weight_unit
    import tgs_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_WIDTH-1:0]  acnt,
    input  logic [COUNT_WIDTH-1:0]  wcnt,
    input  logic [TOTAL_WIDTH-1:0]  tot,
    input  logic [PRIOR_WIDTH-1:0]  alpha_q,
    input  logic [PRIOR_WIDTH-1:0]  beta_q,
    input  logic [PRIOR_WIDTH-1:0]  vocab_beta_q,
    output logic [WEIGHT_WIDTH-1:0] weight,
    output wu_stat_t                stat
);

    localparam int OPW  = ((COUNT_WIDTH + FRAC_BITS > PRIOR_WIDTH) ?
                           (COUNT_WIDTH + FRAC_BITS) : PRIOR_WIDTH) + 1;
    localparam int NCH  = (OPW + FRAC_BITS - 1) / FRAC_BITS;
    localparam int BPW  = NCH * FRAC_BITS;
    localparam int PW   = OPW + BPW;
    localparam int CMPW = (PW > DEN_WIDTH + WEIGHT_WIDTH) ? PW : (DEN_WIDTH + WEIGHT_WIDTH);
    localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int DCW  = $clog2(WEIGHT_WIDTH);

    wu_state_t                state_reg, state_next;
    logic [OPW-1:0]           a_reg;
    logic [BPW-1:0]           b_reg;
    logic [DEN_WIDTH-1:0]     d_reg;
    logic [PW-1:0]            p_reg;
    logic [KW-1:0]            k_reg;
    logic [DEN_WIDTH-1:0]     rem_reg;
    logic [WEIGHT_WIDTH-1:0]  plo_reg;
    logic [WEIGHT_WIDTH-1:0]  q_reg;
    logic [DCW-1:0]           dcnt_reg;
    logic                     done_reg;

    logic [FRAC_BITS-1:0]     chunk;
    logic [OPW+FRAC_BITS-1:0] mprod;
    logic [DEN_WIDTH:0]       rr;
    logic                     rr_ge;
    logic                     over;

    assign chunk = b_reg[k_reg*FRAC_BITS +: FRAC_BITS];
    assign mprod = a_reg * chunk;
    assign rr    = {rem_reg, plo_reg[WEIGHT_WIDTH-1]};
    assign rr_ge = rr >= {1'b0, d_reg};
    assign over  = CMPW'(p_reg) >= (CMPW'(d_reg) << WEIGHT_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == WU_CHK) && ((d_reg == '0) || over)) ||
                         ((state_reg == WU_DIV) && (dcnt_reg == DCW'(WEIGHT_WIDTH - 1)));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WU_IDLE:
            begin
                if (start)
                begin
                    state_next = WU_MUL;
                end
            end
            WU_MUL:
            begin
                if (k_reg == '0)
                begin
                    state_next = WU_CHK;
                end
            end
            WU_CHK:
            begin
                if ((d_reg == '0) || over)
                begin
                    state_next = WU_IDLE;
                end
                else
                begin
                    state_next = WU_DIV;
                end
            end
            WU_DIV:
            begin
                if (dcnt_reg == DCW'(WEIGHT_WIDTH - 1))
                begin
                    state_next = WU_IDLE;
                end
            end
            default: state_next = WU_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            WU_IDLE:
            begin
                if (start)
                begin
                    a_reg <= OPW'({acnt, {FRAC_BITS{1'b0}}}) + OPW'(alpha_q);
                    b_reg <= BPW'({wcnt, {FRAC_BITS{1'b0}}}) + BPW'(beta_q);
                    d_reg <= DEN_WIDTH'({tot, {FRAC_BITS{1'b0}}}) + DEN_WIDTH'(vocab_beta_q);
                    p_reg <= '0;
                    k_reg <= KW'(NCH - 1);
                end
            end
            WU_MUL:
            begin
                p_reg <= (p_reg << FRAC_BITS) + PW'(mprod);
                k_reg <= k_reg - KW'(1);
            end
            WU_CHK:
            begin
                if (d_reg == '0)
                begin
                    q_reg <= (p_reg != '0) ? '1 : '0;
                end
                else if (over)
                begin
                    q_reg <= '1;
                end
                else
                begin
                    q_reg    <= '0;
                    rem_reg  <= DEN_WIDTH'(p_reg >> WEIGHT_WIDTH);
                    plo_reg  <= p_reg[WEIGHT_WIDTH-1:0];
                    dcnt_reg <= '0;
                end
            end
            WU_DIV:
            begin
                rem_reg  <= rr_ge ? DEN_WIDTH'(rr - {1'b0, d_reg}) : DEN_WIDTH'(rr);
                q_reg    <= {q_reg[WEIGHT_WIDTH-2:0], rr_ge};
                plo_reg  <= {plo_reg[WEIGHT_WIDTH-2:0], 1'b0};
                dcnt_reg <= dcnt_reg + DCW'(1);
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign weight    = q_reg;
    assign stat.busy = state_reg != WU_IDLE;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/tgs_checker.sv -----
// Port-level checks of the topic Gibbs token sampler, bound to the top level.
module tgs_checker
    import tgs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [TOPIC_WIDTH-1:0] new_topic,
    input logic                   count_error
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_topic) && $stable(count_error))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second token taken while one is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared in the cycle after a token was taken");

endmodule

bind topic_gibbs_token_sampler tgs_checker u_tgs_checker (.*);

// ----- sim/tgs_checker.sv -----
// Checker for the topic Gibbs token sampler: watches the channels, predicts and compares.
module tgs_scoreboard
    import tgs_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             action,
    input  logic [WORD_ID_WIDTH-1:0]         word_id,
    input  logic [AUTHOR_ID_WIDTH-1:0]       author_id,
    input  logic signed [CITED_ID_WIDTH-1:0] cited_id,
    input  logic [TOPIC_WIDTH-1:0]           old_topic,
    input  logic [UNIFORM_WIDTH-1:0]         uniform,
    input  logic                             held_out,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [TOPIC_WIDTH-1:0]           new_topic,
    input  logic                             count_error,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]         cfg_index,
    input  logic [PRIOR_WIDTH-1:0]           cfg_data,
    output int                               fail_count,
    output int                               pending
);

    localparam int NT = NUM_TOPICS_DEF;
    localparam int CW = COUNT_WIDTH_DEF;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = '1;
    localparam logic [WEIGHT_WIDTH-1:0] WT_MAX = '1;

    typedef struct packed {
        logic [TOPIC_WIDTH-1:0] topic;
        logic                   err;
    } topic_result_t;

    logic [CW-1:0]          word_cnt [VOCAB_SIZE_DEF*NT];
    logic [CW-1:0]          author_cnt [NUM_AUTHORS_DEF*NT];
    logic [CW-1:0]          cited_cnt [NUM_AUTHORS_DEF*NT];
    logic [TOTAL_WIDTH-1:0] tot [NT];
    logic [TOTAL_WIDTH-1:0] cited_tot [NT];
    logic [PAIR_WIDTH-1:0]  last_author;
    logic [PAIR_WIDTH-1:0]  last_cited;
    logic [PRIOR_WIDTH-1:0] alpha;
    logic [PRIOR_WIDTH-1:0] beta;
    logic [PRIOR_WIDTH-1:0] vbeta;
    topic_result_t          awaited [$];

    function automatic logic [WEIGHT_WIDTH-1:0] topic_weight(logic [CW-1:0] ac,
                                                             logic [CW-1:0] wc,
                                                             logic [TOTAL_WIDTH-1:0] tc);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        num = (({108'd0, ac} << 16) + alpha) * (({108'd0, wc} << 16) + beta);
        den = ({104'd0, tc} << 16) + vbeta;
        if (den == 0)
            return (num != 0) ? WT_MAX : '0;
        q = num / den;
        return (q > {80'd0, WT_MAX}) ? WT_MAX : q[WEIGHT_WIDTH-1:0];
    endfunction

    function automatic topic_result_t resample_token(logic act,
                                                     logic [WORD_ID_WIDTH-1:0] w,
                                                     logic [AUTHOR_ID_WIDTH-1:0] a,
                                                     logic [CITED_ID_WIDTH-1:0] c,
                                                     logic [TOPIC_WIDTH-1:0] old,
                                                     logic [UNIFORM_WIDTH-1:0] uni,
                                                     logic held);
        topic_result_t r;
        logic [WEIGHT_WIDTH-1:0] wt [NT];
        logic [63:0] z;
        logic [63:0] run;
        logic [127:0] prod;
        logic [63:0] u;
        int wb;
        int ab;
        int cb;
        int pick;
        logic has_cite;
        logic use_cite;
        wb = int'(w) * NT;
        ab = int'(a) * NT;
        cb = int'(c[9:0]) * NT;
        has_cite = !c[10];
        r.err = 1'b0;
        r.topic = old;
        if (act == ACT_INIT) begin
            if (word_cnt[wb+old] != CNT_MAX) word_cnt[wb+old]++;
            if (author_cnt[ab+old] != CNT_MAX) author_cnt[ab+old]++;
            if (tot[old] != TOT_MAX) tot[old]++;
            if (has_cite && !held) begin
                if (cited_cnt[cb+old] != CNT_MAX) cited_cnt[cb+old]++;
                if (cited_tot[old] != TOT_MAX) cited_tot[old]++;
            end
            return r;
        end
        if (!held && author_cnt[ab+old] == 0) begin
            r.err = 1'b1;
            return r;
        end
        use_cite = !held && has_cite && ({1'b0, a} != last_author || c != last_cited);
        if (word_cnt[wb+old] != 0) word_cnt[wb+old]--;
        if (author_cnt[ab+old] != 0) author_cnt[ab+old]--;
        if (use_cite) begin
            if (cited_cnt[cb+old] != 0) cited_cnt[cb+old]--;
            if (cited_tot[old] != 0) cited_tot[old]--;
        end
        if (tot[old] != 0) tot[old]--;
        z = '0;
        for (int t = 0; t < NT; t++) begin
            wt[t] = topic_weight(author_cnt[ab+t], word_cnt[wb+t], tot[t]);
            z += wt[t];
        end
        prod = {64'd0, z} * {112'd0, uni};
        u = prod[79:16];
        pick = 0;
        run = wt[0];
        while (u > run && pick + 1 < NT) begin
            pick++;
            run += wt[pick];
        end
        if (word_cnt[wb+pick] != CNT_MAX) word_cnt[wb+pick]++;
        if (author_cnt[ab+pick] != CNT_MAX) author_cnt[ab+pick]++;
        if (use_cite) begin
            if (cited_cnt[cb+pick] != CNT_MAX) cited_cnt[cb+pick]++;
            if (cited_tot[pick] != TOT_MAX) cited_tot[pick]++;
        end
        if (tot[pick] != TOT_MAX) tot[pick]++;
        if (!held) begin
            last_author = {1'b0, a};
            last_cited = c;
        end
        r.topic = pick[TOPIC_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        topic_result_t seen;
        topic_result_t want;
        if (!rst_n) begin
            foreach (word_cnt[i]) word_cnt[i] = '0;
            foreach (author_cnt[i]) author_cnt[i] = '0;
            foreach (cited_cnt[i]) cited_cnt[i] = '0;
            foreach (tot[i]) tot[i] = '0;
            foreach (cited_tot[i]) cited_tot[i] = '0;
            last_author = PAIR_NONE;
            last_cited = PAIR_NONE;
            alpha = ALPHA_RESET;
            beta = BETA_RESET;
            vbeta = VOCAB_BETA_RESET;
            awaited.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ALPHA:      alpha = cfg_data;
                    CFG_BETA:       beta = cfg_data;
                    CFG_VOCAB_BETA: vbeta = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                seen.topic = new_topic;
                seen.err = count_error;
                if (awaited.size() == 0) begin
                    $error("unexpected result beat: new_topic %0d count_error %0b",
                           seen.topic, seen.err);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (seen.topic !== want.topic) begin
                        $error("new_topic: expected %0d, actual %0d", want.topic, seen.topic);
                        fail_count++;
                    end
                    if (seen.err !== want.err) begin
                        $error("count_error: expected %0b, actual %0b", want.err, seen.err);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited = {awaited, resample_token(action, word_id, author_id, cited_id,
                                                   old_topic, uniform, held_out)};
        end
        pending = awaited.size();
    end

endmodule

// ----- sim/tb_topic_gibbs_token_sampler.sv -----
// Testbench top of the topic Gibbs token sampler: stimulus, configuration phases and verdict.
module tb_topic_gibbs_token_sampler;
    import tgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int PHASE_ITEMS    = 345;
    localparam int CALM_ITEMS     = 150;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic                             action;
    logic [WORD_ID_WIDTH-1:0]         word_id;
    logic [AUTHOR_ID_WIDTH-1:0]       author_id;
    logic signed [CITED_ID_WIDTH-1:0] cited_id;
    logic [TOPIC_WIDTH-1:0]           old_topic;
    logic [UNIFORM_WIDTH-1:0]         uniform;
    logic                             held_out;
    logic                             out_valid;
    logic                             out_ready;
    logic [TOPIC_WIDTH-1:0]           new_topic;
    logic                             count_error;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]         cfg_index;
    logic [PRIOR_WIDTH-1:0]           cfg_data;
    int                               fail_count;
    int                               pending;

    int  tokens_sent;
    int  topics_back;
    int  idle_cycles;
    int  stall_left;
    bit  calm;
    logic [AUTHOR_ID_WIDTH-1:0] pair_author;
    logic [CITED_ID_WIDTH-1:0]  pair_cited;

    topic_gibbs_token_sampler i_dut (.*);

    tgs_scoreboard i_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
            out_ready = 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            topics_back++;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_token(logic act, logic [WORD_ID_WIDTH-1:0] w,
                              logic [AUTHOR_ID_WIDTH-1:0] a, logic [CITED_ID_WIDTH-1:0] c,
                              logic [TOPIC_WIDTH-1:0] t, logic [UNIFORM_WIDTH-1:0] u,
                              logic held);
        int gap;
        action = act;
        word_id = w;
        author_id = a;
        cited_id = c;
        old_topic = t;
        uniform = u;
        held_out = held;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tokens_sent++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end else begin
            in_valid = 1'b0;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [PRIOR_WIDTH-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (topics_back != tokens_sent)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_token;
        logic [AUTHOR_ID_WIDTH-1:0] a;
        logic [CITED_ID_WIDTH-1:0]  c;
        logic [WORD_ID_WIDTH-1:0]   w;
        logic [TOPIC_WIDTH-1:0]     t;
        logic                       act;
        logic                       held;
        if ($urandom_range(0, 19) == 0) begin
            send_token(1'($urandom), 12'($urandom), 10'($urandom), 11'($urandom),
                       6'($urandom), 16'($urandom), 1'($urandom));
            return;
        end
        act = ($urandom_range(0, 3) == 0) ? ACT_INIT : ACT_RESAMPLE;
        held = ($urandom_range(0, 6) == 0);
        w = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 7));
        t = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0) begin
            a = pair_author;
            c = pair_cited;
        end else begin
            a = ($urandom_range(0, 9) == 0) ? 10'h3FF : 10'($urandom_range(0, 5));
            case ($urandom_range(0, 4))
                0: c = {1'b1, 10'($urandom)};
                1: c = 11'h3FF;
                default: c = 11'($urandom_range(0, 3));
            endcase
        end
        pair_author = a;
        pair_cited = c;
        send_token(act, w, a, c, t, 16'($urandom), held);
    endtask

    initial
    begin
        logic [PRIOR_WIDTH-1:0] cfg_set [5][3];
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_RESAMPLE;
        word_id = '0;
        author_id = '0;
        cited_id = '0;
        old_topic = '0;
        uniform = '0;
        held_out = 1'b0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = CFG_ALPHA;
        cfg_data = '0;
        tokens_sent = 0;
        topics_back = 0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        pair_author = '0;
        pair_cited = '0;
        cfg_set[0] = '{ALPHA_RESET, BETA_RESET, VOCAB_BETA_RESET};
        cfg_set[1] = '{32'd0, 32'd0, 32'd0};
        cfg_set[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        cfg_set[3] = '{$urandom, $urandom_range(0, 65535), $urandom};
        cfg_set[4] = '{32'd1, 32'hFFFF_FFFF, 32'd0};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send_token(ACT_INIT, 12'd0, 10'd0, 11'd0, 6'd0, 16'd0, 1'b0);
        send_token(ACT_INIT, 12'hFFF, 10'h3FF, 11'h3FF, 6'd63, 16'hFFFF, 1'b0);
        send_token(ACT_INIT, 12'd1, 10'd0, 11'h7FF, 6'd1, 16'd0, 1'b0);
        send_token(ACT_INIT, 12'd2, 10'd1, 11'd5, 6'd2, 16'd0, 1'b1);
        send_token(ACT_INIT, 12'd0, 10'd1, 11'h400, 6'd0, 16'd0, 1'b0);
        send_token(ACT_RESAMPLE, 12'd0, 10'd0, 11'd0, 6'd0, 16'd0, 1'b0);
        send_token(ACT_RESAMPLE, 12'd0, 10'd0, 11'd0, 6'd0, 16'hFFFF, 1'b0);
        send_token(ACT_RESAMPLE, 12'hFFF, 10'h3FF, 11'h3FF, 6'd63, 16'h8000, 1'b0);
        send_token(ACT_RESAMPLE, 12'd1, 10'd0, 11'h7FF, 6'd1, 16'h1234, 1'b0);
        send_token(ACT_RESAMPLE, 12'd9, 10'd900, 11'd3, 6'd7, 16'h4000, 1'b0);
        send_token(ACT_RESAMPLE, 12'd9, 10'd900, 11'd3, 6'd7, 16'h4000, 1'b1);
        send_token(ACT_RESAMPLE, 12'd2, 10'd1, 11'd5, 6'd2, 16'hC000, 1'b1);
        send_token(ACT_RESAMPLE, 12'd0, 10'd1, 11'h400, 6'd0, 16'h00FF, 1'b0);
        send_token(ACT_RESAMPLE, 12'd0, 10'd1, 11'h400, 6'd0, 16'hFF00, 1'b0);
        send_token(ACT_RESAMPLE, 12'd5, 10'd0, 11'h555, 6'd42, 16'hAAAA, 1'b0);
        send_token(ACT_RESAMPLE, 12'hAAA, 10'h2AA, 11'h2AA, 6'h15, 16'h5555, 1'b1);
        drain();

        for (int p = 0; p < 5; p++) begin
            for (int r = 0; r < 3; r++)
                write_reg(r[CFG_IDX_WIDTH-1:0], cfg_set[p][r]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == PHASE_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                random_token();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
